@@ hdl/ludas_pkg.sv @@
// ----------------------------------------------------------------------------
// ludas_pkg
// Shared constants for the LU decomposition and solve core and its checker.
// ----------------------------------------------------------------------------
package ludas_pkg;

  // Number format: signed Q8.24.
  localparam int VALUE_W   = 32;
  localparam int FRAC_W    = 24;
  localparam int MAX_ORDER = 8;
  localparam int IDX_W     = 3;
  localparam int ADDR_W    = 7;
  localparam int NUM_W     = VALUE_W + FRAC_W;
  localparam int DCNT_W    = 6;

  // Right-hand-side words live above the factor words in the shared store.
  localparam logic [ADDR_W-1:0] RHS_BASE = 7'd64;

  // Bit positions inside out_tuser.
  localparam int OUT_KIND_BIT   = 0;
  localparam int OUT_SING_BIT   = 1;
  localparam int OUT_PARITY_BIT = 2;
  localparam int OUT_SAT_BIT    = 3;
  localparam int OUT_USER_W     = 4;

  // Result kinds.
  localparam logic KIND_STATUS   = 1'b0;
  localparam logic KIND_SOLUTION = 1'b1;

  // Input kinds.
  localparam logic IN_MATRIX = 1'b0;
  localparam logic IN_RHS    = 1'b1;

endpackage

@@ hdl/lu_decompose_and_solve_core.sv @@
// ----------------------------------------------------------------------------
// lu_decompose_and_solve_core
// Crout LU factorization with partial pivoting and a linear solve in Q8.24.
// ----------------------------------------------------------------------------
// Channel   Dir  Ports                          Contents
// in_       in   tvalid/tready/tdata/tuser      tdata: value; tuser: kind
// out_      out  tvalid/tready/tdata/tuser/tlast tdata: solution;
//                                               tuser: kind, singular, parity, saturated
// cfg_      in   wr_en/wr_data                  order n of the matrix
//
// Loading takes one cycle per word. Factoring and solving run on one shared
// multiply, subtract and divide unit: a multiply-subtract step passes through
// the read, multiply, round and subtract states, and a division makes one
// quotient bit per step. in_tready is low meanwhile. Reset is synchronous and
// needs no clearing pass. A stalled result holds the sequencer only when the
// next result is due.
// ----------------------------------------------------------------------------
module lu_decompose_and_solve_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] solution
  output logic [3:0]  out_tuser,  // [0] result_kind [1] singular [2] parity_negative [3] saturated
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_INIT2, S_MAC_RD, S_MAC_MUL, S_MAC_RND, S_MAC_SUB,
    S_DIV_SET, S_DIV, S_DIV_FIN, S_WRITE, S_SW_CHK, S_SW_RD, S_SW_W1,
    S_SW_W2, S_PIV_CHK, S_ST_EMIT, S_E_RD, S_E_OUT
  } state_t;

  typedef enum logic [1:0] {PH_UP, PH_DIV, PH_FWD, PH_BWD} phase_t;

  localparam logic [31:0] VMAX = 32'h7fff_ffff;
  localparam logic [31:0] VMIN = 32'h8000_0000;

  state_t state_r;
  phase_t phase_r;

  logic [3:0]  size_r;
  logic [2:0]  mrow_r, mcol_r, ridx_r;
  logic        rhs_ph_r;
  logic [2:0]  i_r, j_r, best_r;
  logic [3:0]  k_r, kend_r;
  logic [31:0] big_r;
  logic        parity_r, sing_r, ovf_r;
  logic [2:0]  pv_r [MAX_ORDER_C];
  logic signed [31:0] acc_r, div_r;
  logic [63:0] prod_r;
  logic        pneg_r;
  logic [31:0] mres_r;
  logic [55:0] num_r, q_r;
  logic [31:0] rem_r, d_r;
  logic        qneg_r;
  logic [5:0]  dcnt_r;

  localparam int MAX_ORDER_C = ludas_pkg::MAX_ORDER;

  // Shared store: factor words then right-hand-side words.
  logic [31:0] mem [72];
  logic [6:0]  ra, rb, wa;
  logic        we;
  logic [31:0] wd;
  logic signed [31:0] rd_a_r, rd_b_r;

  logic        out_valid_r, out_last_r;
  logic [31:0] out_data_r;
  logic [3:0]  out_user_r;

  function automatic logic [6:0] a_addr(input logic [2:0] r, input logic [2:0] c);
    a_addr = {1'b0, r, c};
  endfunction

  function automatic logic [6:0] r_addr(input logic [2:0] x);
    r_addr = ludas_pkg::RHS_BASE | {4'b0000, x};
  endfunction

  // Effective order, clamped to 1..8.
  logic [3:0] n;
  logic [2:0] nm1;
  always_comb begin
    if (size_r == 4'd0) begin
      n = 4'd1;
    end else if (size_r > 4'd8) begin
      n = 4'd8;
    end else begin
      n = size_r;
    end
    nm1 = 3'(n - 4'd1);
  end

  logic in_acc, out_free, mat_ok, rhs_ok;
  assign in_tready = (state_r == S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign mat_ok    = in_acc && !rhs_ph_r && (in_tuser == ludas_pkg::IN_MATRIX);
  assign rhs_ok    = in_acc && rhs_ph_r && (in_tuser == ludas_pkg::IN_RHS);

  // Read addresses for the shared store.
  always_comb begin
    ra = r_addr(k_r[2:0]);
    rb = r_addr(k_r[2:0]);
    case (state_r)
      S_INIT: begin
        case (phase_r)
          PH_UP:  begin ra = a_addr(i_r, j_r);      rb = a_addr(j_r, j_r); end
          PH_DIV: begin ra = a_addr(i_r, j_r);      rb = a_addr(j_r, j_r); end
          PH_FWD: begin ra = r_addr(pv_r[i_r]);     rb = r_addr(i_r);      end
          default: begin ra = r_addr(i_r);          rb = a_addr(i_r, i_r); end
        endcase
      end
      S_MAC_RD: begin
        ra = a_addr(i_r, k_r[2:0]);
        if (phase_r == PH_UP) begin
          rb = a_addr(k_r[2:0], j_r);
        end else begin
          rb = r_addr(k_r[2:0]);
        end
      end
      S_SW_RD: begin
        ra = a_addr(best_r, k_r[2:0]);
        rb = a_addr(j_r, k_r[2:0]);
      end
      default: ;
    endcase
  end

  // Write port of the shared store.
  always_comb begin
    we = 1'b0;
    wa = a_addr(i_r, j_r);
    wd = acc_r;
    case (state_r)
      S_LOAD: begin
        if (mat_ok) begin
          we = 1'b1; wa = a_addr(mrow_r, mcol_r); wd = in_tdata;
        end else if (rhs_ok) begin
          we = 1'b1; wa = r_addr(ridx_r); wd = in_tdata;
        end
      end
      S_INIT2: begin
        if (phase_r == PH_FWD) begin
          we = 1'b1; wa = r_addr(pv_r[i_r]); wd = rd_b_r;
        end
      end
      S_WRITE: begin
        we = 1'b1;
        if (phase_r == PH_UP || phase_r == PH_DIV) begin
          wa = a_addr(i_r, j_r);
        end else begin
          wa = r_addr(i_r);
        end
      end
      S_SW_W1: begin we = 1'b1; wa = a_addr(best_r, k_r[2:0]); wd = rd_b_r; end
      S_SW_W2: begin we = 1'b1; wa = a_addr(j_r, k_r[2:0]);    wd = acc_r;  end
      default: ;
    endcase
  end

  // Store with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_r <= mem[ra];
    rd_b_r <= mem[rb];
  end

  // Shared arithmetic: product magnitude, rounding, saturation.
  logic [31:0] mag_a, mag_b, mag_acc, mag_div;
  logic [63:0] prod_rnd;
  logic [39:0] prod_q;
  logic        mul_sat;
  logic [31:0] mul_val;
  always_comb begin
    mag_a    = rd_a_r[31] ? 32'(-rd_a_r) : rd_a_r;
    mag_b    = rd_b_r[31] ? 32'(-rd_b_r) : rd_b_r;
    mag_acc  = acc_r[31] ? 32'(-acc_r) : acc_r;
    mag_div  = div_r[31] ? 32'(-div_r) : div_r;
    prod_rnd = prod_r + 64'h0000_0000_0080_0000;
    prod_q   = prod_rnd[63:24];
    mul_sat  = pneg_r ? (prod_q > 40'h00_8000_0000) : (prod_q > 40'h00_7fff_ffff);
    if (mul_sat) begin
      mul_val = pneg_r ? VMIN : VMAX;
    end else begin
      mul_val = pneg_r ? 32'(-prod_q) : prod_q[31:0];
    end
  end

  // Saturating subtract of the rounded product from the accumulator.
  logic signed [32:0] diff;
  logic        sub_sat;
  logic [31:0] sub_val;
  always_comb begin
    diff    = {acc_r[31], acc_r} - {mres_r[31], mres_r};
    sub_sat = diff[32] != diff[31];
    if (sub_sat) begin
      sub_val = diff[32] ? VMIN : VMAX;
    end else begin
      sub_val = diff[31:0];
    end
  end

  // One restoring division step, and the final rounding.
  logic [32:0] rem_sh;
  logic        qbit;
  logic [31:0] rem_new;
  logic [56:0] q_rnd;
  logic        div_sat;
  logic [31:0] div_val;
  always_comb begin
    rem_sh  = {rem_r, num_r[55]};
    qbit    = rem_sh >= {1'b0, d_r};
    rem_new = qbit ? 32'(rem_sh - {1'b0, d_r}) : rem_sh[31:0];
    q_rnd   = {1'b0, q_r} + (({rem_r, 1'b0} >= {1'b0, d_r}) ? 57'd1 : 57'd0);
    div_sat = qneg_r ? (q_rnd > 57'h0_8000_0000) : (q_rnd > 57'h0_7fff_ffff);
    if (div_sat) begin
      div_val = qneg_r ? VMIN : VMAX;
    end else begin
      div_val = qneg_r ? 32'(-q_rnd) : q_rnd[31:0];
    end
  end

  logic [2:0] i_inc;
  assign i_inc = 3'(i_r + 3'd1);

  // Sequencer, counters, flags and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      phase_r     <= PH_UP;
      size_r      <= 4'd8;
      mrow_r      <= '0;
      mcol_r      <= '0;
      ridx_r      <= '0;
      rhs_ph_r    <= 1'b0;
      parity_r    <= 1'b0;
      sing_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      kend_r      <= '0;
      best_r      <= '0;
      dcnt_r      <= '0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        size_r   <= cfg_wr_data;
        mrow_r   <= '0;
        mcol_r   <= '0;
        ridx_r   <= '0;
        rhs_ph_r <= 1'b0;
      end
      case (state_r)
        // Take matrix and right-hand-side words.
        S_LOAD: begin
          if (mat_ok) begin
            if (mrow_r == 3'd0 && mcol_r == 3'd0) begin
              parity_r <= 1'b0;
              sing_r   <= 1'b0;
              ovf_r    <= 1'b0;
            end
            if (mcol_r == nm1) begin
              mcol_r <= '0;
              if (mrow_r == nm1) begin
                mrow_r   <= '0;
                rhs_ph_r <= 1'b1;
                phase_r  <= PH_UP;
                i_r      <= '0;
                j_r      <= '0;
                k_r      <= '0;
                kend_r   <= '0;
                state_r  <= S_INIT;
              end else begin
                mrow_r <= 3'(mrow_r + 3'd1);
              end
            end else begin
              mcol_r <= 3'(mcol_r + 3'd1);
            end
          end else if (rhs_ok) begin
            if (ridx_r == nm1) begin
              ridx_r   <= '0;
              rhs_ph_r <= 1'b0;
              i_r      <= '0;
              k_r      <= '0;
              kend_r   <= '0;
              phase_r  <= PH_FWD;
              state_r  <= sing_r ? S_E_RD : S_INIT;
            end else begin
              ridx_r <= 3'(ridx_r + 3'd1);
            end
          end
        end
        S_INIT: state_r <= S_INIT2;
        // Start value and divisor arrive from the store.
        S_INIT2: begin
          acc_r <= rd_a_r;
          div_r <= rd_b_r;
          if (k_r < kend_r) begin
            state_r <= S_MAC_RD;
          end else if (phase_r == PH_DIV || phase_r == PH_BWD) begin
            state_r <= S_DIV_SET;
          end else begin
            state_r <= S_WRITE;
          end
        end
        // Multiply-subtract step.
        S_MAC_RD: state_r <= S_MAC_MUL;
        S_MAC_MUL: begin
          prod_r  <= mag_a * mag_b;
          pneg_r  <= rd_a_r[31] ^ rd_b_r[31];
          state_r <= S_MAC_RND;
        end
        S_MAC_RND: begin
          mres_r <= mul_val;
          if (mul_sat) begin
            ovf_r <= 1'b1;
          end
          state_r <= S_MAC_SUB;
        end
        S_MAC_SUB: begin
          acc_r <= sub_val;
          if (sub_sat) begin
            ovf_r <= 1'b1;
          end
          k_r <= 4'(k_r + 4'd1);
          if (4'(k_r + 4'd1) < kend_r) begin
            state_r <= S_MAC_RD;
          end else if (phase_r == PH_DIV || phase_r == PH_BWD) begin
            state_r <= S_DIV_SET;
          end else begin
            state_r <= S_WRITE;
          end
        end
        // Division, one quotient bit a cycle.
        S_DIV_SET: begin
          num_r   <= {mag_acc, 24'd0};
          d_r     <= mag_div;
          rem_r   <= '0;
          q_r     <= '0;
          qneg_r  <= acc_r[31] ^ div_r[31];
          dcnt_r  <= 6'(ludas_pkg::NUM_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= rem_new;
          num_r  <= {num_r[54:0], 1'b0};
          q_r    <= {q_r[54:0], qbit};
          dcnt_r <= 6'(dcnt_r - 6'd1);
          if (dcnt_r == 6'd0) begin
            state_r <= S_DIV_FIN;
          end
        end
        S_DIV_FIN: begin
          acc_r <= div_val;
          if (div_sat) begin
            ovf_r <= 1'b1;
          end
          state_r <= S_WRITE;
        end
        // Result written; advance the loop indices.
        S_WRITE: begin
          case (phase_r)
            PH_UP: begin
              if (i_r == j_r) begin
                best_r <= j_r;
                big_r  <= mag_acc;
              end else if (i_r > j_r && mag_acc > big_r) begin
                best_r <= i_r;
                big_r  <= mag_acc;
              end
              if (i_r == nm1) begin
                state_r <= S_SW_CHK;
              end else begin
                i_r     <= i_inc;
                k_r     <= '0;
                kend_r  <= ({1'b0, i_inc} < {1'b0, j_r}) ? {1'b0, i_inc} : {1'b0, j_r};
                state_r <= S_INIT;
              end
            end
            PH_DIV: begin
              k_r    <= '0;
              kend_r <= '0;
              if (i_r == nm1) begin
                j_r     <= 3'(j_r + 3'd1);
                i_r     <= '0;
                phase_r <= PH_UP;
              end else begin
                i_r <= i_inc;
              end
              state_r <= S_INIT;
            end
            PH_FWD: begin
              state_r <= S_INIT;
              if (i_r == nm1) begin
                phase_r <= PH_BWD;
                k_r     <= n;
                kend_r  <= n;
              end else begin
                i_r    <= i_inc;
                k_r    <= '0;
                kend_r <= {1'b0, i_inc};
              end
            end
            default: begin
              if (i_r == 3'd0) begin
                k_r     <= '0;
                state_r <= S_E_RD;
              end else begin
                i_r     <= 3'(i_r - 3'd1);
                k_r     <= {1'b0, i_r};
                kend_r  <= n;
                state_r <= S_INIT;
              end
            end
          endcase
        end
        // Pivot row swap.
        S_SW_CHK: begin
          pv_r[j_r] <= best_r;
          k_r       <= '0;
          if (best_r != j_r) begin
            parity_r <= ~parity_r;
            state_r  <= S_SW_RD;
          end else begin
            state_r <= S_PIV_CHK;
          end
        end
        S_SW_RD: state_r <= S_SW_W1;
        S_SW_W1: begin
          acc_r   <= rd_a_r;
          state_r <= S_SW_W2;
        end
        S_SW_W2: begin
          if (k_r[2:0] == nm1) begin
            state_r <= S_PIV_CHK;
          end else begin
            k_r     <= 4'(k_r + 4'd1);
            state_r <= S_SW_RD;
          end
        end
        // Zero pivot stops the factoring; else scale the column below, if any.
        S_PIV_CHK: begin
          k_r    <= '0;
          kend_r <= '0;
          if (big_r == 32'd0) begin
            sing_r  <= 1'b1;
            state_r <= S_ST_EMIT;
          end else if (j_r == nm1) begin
            state_r <= S_ST_EMIT;
          end else begin
            phase_r <= PH_DIV;
            i_r     <= 3'(j_r + 3'd1);
            state_r <= S_INIT;
          end
        end
        S_ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '0;
            out_user_r  <= {ovf_r, parity_r, sing_r, ludas_pkg::KIND_STATUS};
            out_last_r  <= 1'b0;
            state_r     <= S_LOAD;
          end
        end
        // Emit the solution words.
        S_E_RD: state_r <= S_E_OUT;
        S_E_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= sing_r ? 32'd0 : rd_a_r;
            out_user_r  <= {ovf_r, parity_r, sing_r, ludas_pkg::KIND_SOLUTION};
            out_last_r  <= (k_r[2:0] == nm1);
            if (k_r[2:0] == nm1) begin
              state_r <= S_LOAD;
            end else begin
              k_r     <= 4'(k_r + 4'd1);
              state_r <= S_E_RD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

@@ hdl/ludas_checker.sv @@
// ----------------------------------------------------------------------------
// ludas_checker
// Port-level checks for the LU decomposition and solve core.
// ----------------------------------------------------------------------------
module ludas_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [3:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled result word holds its data.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // A status word never ends a run and carries zero data.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[ludas_pkg::OUT_KIND_BIT] == ludas_pkg::KIND_STATUS)
    |-> !out_tlast && out_tdata == 32'd0)
    else $error("status word malformed");

  // Solutions of a singular matrix are zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[ludas_pkg::OUT_KIND_BIT] && out_tuser[ludas_pkg::OUT_SING_BIT]
    |-> out_tdata == 32'd0)
    else $error("singular solution word not zero");

  // The singular and parity flags do not change between words of one solution run.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser[ludas_pkg::OUT_KIND_BIT] && !out_tlast
    ##1 out_tvalid |-> out_tuser[ludas_pkg::OUT_SING_BIT] == $past(out_tuser[ludas_pkg::OUT_SING_BIT])
    && out_tuser[ludas_pkg::OUT_PARITY_BIT] == $past(out_tuser[ludas_pkg::OUT_PARITY_BIT]))
    else $error("flags changed within a solution run");

endmodule

bind lu_decompose_and_solve_core ludas_checker u_ludas_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

@@ dv/tb_lu_decompose_and_solve_core.sv @@
// ----------------------------------------------------------------------------
// tb_lu_decompose_and_solve_core
// Self-checking bench for the LU factor and solve core. A short stimulus
// table covers zero, extreme and swapped matrices and misplaced words. Random
// systems of several orders follow, with bursty input and a stalling output.
// Every result word is compared with a fixed-point model of the factoring.
// ----------------------------------------------------------------------------
module tb_lu_decompose_and_solve_core;
  import ludas_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic        kind;
    logic [31:0] solution;
    logic        singular;
    logic        parity;
    logic        saturated;
    logic        last;
  } result_t;

  typedef struct {
    logic        kind;
    logic [31:0] value;
    bit          typed;
    logic        singular;
    logic        parity;
  } table_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;

  lu_decompose_and_solve_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Model state of the factoring engine.
  longint  lu_mat [MAX_ORDER*MAX_ORDER];
  longint  rhs_vec [MAX_ORDER];
  int      pivot_of [MAX_ORDER];
  int      words_loaded;
  bit      parity_odd, found_singular, hit_sat;
  logic [3:0] order_reg;

  result_t solution_queue[$];
  int      errors;
  int      burst_left;
  int      stall_mode, stall_count;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Saturating fixed-point helpers.
  function automatic longint sat_mag(bit neg, longint unsigned mag);
    longint unsigned limit;
    limit = neg ? 64'd2147483648 : 64'd2147483647;
    if (mag > limit) begin
      hit_sat = 1'b1;
      return neg ? SAT_LO : SAT_HI;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint q_sub(longint a, longint b);
    longint d;
    d = a - b;
    if (d > SAT_HI) begin hit_sat = 1'b1; return SAT_HI; end
    if (d < SAT_LO) begin hit_sat = 1'b1; return SAT_LO; end
    return d;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    longint unsigned p;
    p = longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b);
    p = (p + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
    return sat_mag((a < 0) != (b < 0), p);
  endfunction

  function automatic longint q_div(longint a, longint b);
    longint unsigned num, den, q, r;
    num = longint'(a < 0 ? -a : a) << FRAC_W;
    den = b < 0 ? -b : b;
    q = num / den;
    r = num % den;
    if (r >= den - r) q++;
    return sat_mag((a < 0) != (b < 0), q);
  endfunction

  function automatic int eff_order();
    if (order_reg == 0) return 1;
    return order_reg > MAX_ORDER ? MAX_ORDER : int'(order_reg);
  endfunction

  // Crout factoring with partial pivoting, stopping at a zero pivot.
  function automatic void factor_matrix(int n);
    int best;
    longint s, t;
    longint unsigned big;
    for (int j = 0; j < n; j++) begin
      best = j;
      big = 0;
      for (int i = 0; i < j; i++) begin
        s = lu_mat[i*MAX_ORDER+j];
        for (int k = 0; k < i; k++)
          s = q_sub(s, q_mul(lu_mat[i*MAX_ORDER+k], lu_mat[k*MAX_ORDER+j]));
        lu_mat[i*MAX_ORDER+j] = s;
      end
      for (int i = j; i < n; i++) begin
        s = lu_mat[i*MAX_ORDER+j];
        for (int k = 0; k < j; k++)
          s = q_sub(s, q_mul(lu_mat[i*MAX_ORDER+k], lu_mat[k*MAX_ORDER+j]));
        lu_mat[i*MAX_ORDER+j] = s;
        if (longint'(s < 0 ? -s : s) > big) begin
          big = s < 0 ? -s : s;
          best = i;
        end
      end
      if (best != j) begin
        for (int k = 0; k < n; k++) begin
          t = lu_mat[best*MAX_ORDER+k];
          lu_mat[best*MAX_ORDER+k] = lu_mat[j*MAX_ORDER+k];
          lu_mat[j*MAX_ORDER+k] = t;
        end
        parity_odd ^= 1'b1;
      end
      pivot_of[j] = best;
      if (lu_mat[j*MAX_ORDER+j] == 0) begin
        found_singular = 1'b1;
        return;
      end
      for (int i = j + 1; i < n; i++)
        lu_mat[i*MAX_ORDER+j] = q_div(lu_mat[i*MAX_ORDER+j], lu_mat[j*MAX_ORDER+j]);
    end
  endfunction

  // Permute, then forward and back substitution.
  function automatic void solve_system(int n);
    longint s;
    int p;
    for (int i = 0; i < n; i++) begin
      p = pivot_of[i];
      s = rhs_vec[p];
      rhs_vec[p] = rhs_vec[i];
      for (int j = 0; j < i; j++)
        s = q_sub(s, q_mul(lu_mat[i*MAX_ORDER+j], rhs_vec[j]));
      rhs_vec[i] = s;
    end
    for (int i = n - 1; i >= 0; i--) begin
      s = rhs_vec[i];
      for (int j = i + 1; j < n; j++)
        s = q_sub(s, q_mul(lu_mat[i*MAX_ORDER+j], rhs_vec[j]));
      rhs_vec[i] = q_div(s, lu_mat[i*MAX_ORDER+i]);
    end
  endfunction

  // Advance the model by one accepted word and queue the results it causes.
  function automatic void predict_word(logic kind, logic [31:0] value);
    int n, nn;
    result_t r;
    n = eff_order();
    nn = n * n;
    if (words_loaded < nn) begin
      if (kind != IN_MATRIX) return;
      if (words_loaded == 0) begin
        parity_odd = 0; found_singular = 0; hit_sat = 0;
      end
      lu_mat[(words_loaded / n)*MAX_ORDER + words_loaded % n] = longint'($signed(value));
      words_loaded++;
      if (words_loaded < nn) return;
      factor_matrix(n);
      r = '{KIND_STATUS, 32'd0, found_singular, parity_odd, hit_sat, 1'b0};
      solution_queue.push_back(r);
      return;
    end
    if (kind != IN_RHS) return;
    rhs_vec[words_loaded - nn] = longint'($signed(value));
    words_loaded++;
    if (words_loaded < nn + n) return;
    words_loaded = 0;
    if (!found_singular) solve_system(n);
    for (int k = 0; k < n; k++) begin
      r = '{KIND_SOLUTION, found_singular ? 32'd0 : rhs_vec[k][31:0],
            found_singular, parity_odd, hit_sat, k == n - 1};
      solution_queue.push_back(r);
    end
  endfunction

  // Send one word, in bursts separated by random gaps.
  task automatic send_word(logic kind, logic [31:0] value);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk) in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        @(negedge clk);
      end
    end else begin
      @(negedge clk);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= value;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    predict_word(kind, value);
  endtask

  // Hold input off until every queued result is out and the core has settled.
  task automatic drain();
    @(negedge clk) in_tvalid <= 1'b0;
    burst_left = 0;
    while (solution_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_order(logic [3:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk) cfg_wr_en <= 1'b0;
    order_reg = v;
    words_loaded = 0;
  endtask

  function automatic logic [31:0] rand_element();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'd0;
      default: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    endcase
  endfunction

  // One random system: a matrix, maybe with a zero column, then its rhs.
  task automatic random_system(int n, bit abandon);
    int zero_col;
    zero_col = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : -1;
    for (int e = 0; e < n * n; e++) begin
      if ($urandom_range(0, 19) == 0) send_word(IN_RHS, $urandom());
      send_word(IN_MATRIX, (e % n == zero_col) ? 32'd0 : rand_element());
      if (abandon && e == n) return;
    end
    for (int e = 0; e < n; e++) begin
      if ($urandom_range(0, 19) == 0) send_word(IN_MATRIX, $urandom());
      send_word(IN_RHS, rand_element());
    end
  endtask

  // Receiver stall pattern: always ready, random, or mostly stalled, picked anew when its counter runs out.
  always @(negedge clk) begin
    if (stall_count == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_count <= 64;
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser[OUT_KIND_BIT], out_tdata, out_tuser[OUT_SING_BIT],
              out_tuser[OUT_PARITY_BIT], out_tuser[OUT_SAT_BIT], out_tlast};
      if (solution_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %h", $time, got);
      end else begin
        want = solution_queue.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected kind %b sol %h sing %b par %b sat %b last %b",
                   $time, want.kind, want.solution, want.singular, want.parity,
                   want.saturated, want.last);
          $display("%0t:          actual kind %b sol %h sing %b par %b sat %b last %b",
                   $time, got.kind, got.solution, got.singular, got.parity,
                   got.saturated, got.last);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    table_row_t rows[$];
    int orders[$];
    int sent;
    result_t typed;
    errors = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_count = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = IN_MATRIX;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    order_reg = 4'd8;
    words_loaded = 0;
    parity_odd = 0; found_singular = 0; hit_sat = 0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed table at order 2: zero matrix, extremes, swap, tie, wrong kinds.
    rows = '{
      '{IN_RHS,    32'h1234_5678, 0, 0, 0},
      '{IN_MATRIX, 32'h0000_0000, 0, 0, 0},
      '{IN_MATRIX, 32'h0000_0000, 0, 0, 0},
      '{IN_MATRIX, 32'h0000_0000, 0, 0, 0},
      '{IN_MATRIX, 32'h0000_0000, 1, 1, 0},
      '{IN_RHS,    32'h7fff_ffff, 0, 0, 0},
      '{IN_RHS,    32'h8000_0000, 0, 0, 0},
      '{IN_MATRIX, 32'h7fff_ffff, 0, 0, 0},
      '{IN_MATRIX, 32'h8000_0000, 0, 0, 0},
      '{IN_MATRIX, 32'h8000_0000, 0, 0, 0},
      '{IN_MATRIX, 32'h7fff_ffff, 0, 0, 0},
      '{IN_MATRIX, 32'hffff_ffff, 0, 0, 0},
      '{IN_RHS,    32'h8000_0000, 0, 0, 0},
      '{IN_RHS,    32'h7fff_ffff, 0, 0, 0},
      '{IN_MATRIX, 32'h0000_0000, 0, 0, 0},
      '{IN_MATRIX, 32'h0100_0000, 0, 0, 0},
      '{IN_MATRIX, 32'h0100_0000, 0, 0, 0},
      '{IN_MATRIX, 32'h0000_0000, 1, 0, 1},
      '{IN_RHS,    32'h0300_0000, 0, 0, 0},
      '{IN_RHS,    32'hfe00_0000, 0, 0, 0},
      '{IN_MATRIX, 32'h0200_0000, 0, 0, 0},
      '{IN_MATRIX, 32'h0100_0000, 0, 0, 0},
      '{IN_MATRIX, 32'hfe00_0000, 0, 0, 0},
      '{IN_MATRIX, 32'h0300_0000, 0, 0, 0},
      '{IN_RHS,    32'h0100_0000, 0, 0, 0}
    };
    write_order(4'd2);
    foreach (rows[i]) begin
      send_word(rows[i].kind, rows[i].value);
      if (rows[i].typed) begin
        // Status words whose flags follow directly from the matrix.
        typed = '{KIND_STATUS, 32'd0, rows[i].singular, rows[i].parity, 1'b0, 1'b0};
        solution_queue[solution_queue.size() - 1] = typed;
      end
    end
    send_word(IN_RHS, 32'h0000_0001);
    drain();

    // Random systems over several orders, including out-of-range settings.
    orders = '{3, 0, 8, 2, 15, 4, 5, 1, 6, 7, 2, 3, 4, 8};
    sent = 0;
    while (sent < 380) begin
      foreach (orders[i]) begin
        write_order(orders[i][3:0]);
        repeat ($urandom_range(1, 3)) begin
          random_system(eff_order(), $urandom_range(0, 9) == 0);
          sent += eff_order() * (eff_order() + 1);
          if ($urandom_range(0, 3) == 0) drain();
        end
        drain();
        if (sent >= 380) break;
      end
    end

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
